>>> rtl/cme_pkg.sv
`default_nettype none

package cme_pkg;

    // Fixed point format of all datapath words.
    localparam int WORD_W    = 32;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int FRAC_BITS = 27;

    // Pixel coordinates and image dimensions.
    localparam int COORD_BITS = 13;
    localparam int DIM_W      = 12;
    localparam int CMP_W      = (COORD_BITS > DIM_W + 1) ? COORD_BITS : DIM_W + 1;

    // Result fields.
    localparam int ITER_W  = 11;
    localparam int LIMIT_W = 10;
    localparam int CLASS_W = 3;
    localparam int STEP_W  = 28;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_X_LEFT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_TOP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd6;

    // Register reset values.
    localparam logic signed [WORD_W-1:0] RST_X_LEFT   = -32'sd268435456;
    localparam logic signed [WORD_W-1:0] RST_Y_TOP    = 32'sd134217728;
    localparam logic [STEP_W-1:0]        RST_X_STEP   = 28'd402653;
    localparam logic [STEP_W-1:0]        RST_Y_STEP   = 28'd268435;
    localparam logic [LIMIT_W-1:0]       RST_MAX_ITER = 10'd400;
    localparam logic [DIM_W-1:0]         RST_WIDTH    = 12'd1000;
    localparam logic [DIM_W-1:0]         RST_HEIGHT   = 12'd1000;

    // Escape radius 2, squared, at twice the fractional bits of a word.
    localparam int              DISK_SHIFT  = 2 * FRAC_BITS + 2;
    localparam bit              DISK_ALWAYS = (DISK_SHIFT >= PROD_W);
    localparam logic [PROD_W-1:0] DISK_LIMIT =
        DISK_ALWAYS ? '0 : (PROD_W'(1) << (DISK_SHIFT % PROD_W));

    // Color classes and their count thresholds.
    localparam logic [CLASS_W-1:0] CLASS_BLACK = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_RED   = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_GREEN = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_BLUE  = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_WHITE = 3'd4;

    localparam logic [ITER_W-1:0] RED_LIMIT   = 11'd6;
    localparam logic [ITER_W-1:0] GREEN_LIMIT = 11'd14;
    localparam logic [ITER_W-1:0] BLUE_LIMIT  = 11'd25;

    // Clamp a wide signed value to the signed word range.
    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'({1'b0, {(WORD_W-1){1'b1}}});
        lo = -hi - PROD_W'(1);
        if (v > hi) begin
            return {1'b0, {(WORD_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(WORD_W-1){1'b0}}};
        end
        return WORD_W'(v);
    endfunction

    // Fixed point product scaling: arithmetic shift rounds toward minus infinity.
    function automatic logic signed [WORD_W-1:0] fx_scale(input logic signed [PROD_W-1:0] v);
        return sat_word(v >>> FRAC_BITS);
    endfunction

endpackage

`default_nettype wire

>>> rtl/cme_mul.sv
`default_nettype none

module cme_mul (
    input  wire logic                                   i_clk,
    input  wire logic signed [cme_pkg::WORD_W-1:0]      i_a,
    input  wire logic signed [cme_pkg::WORD_W-1:0]      i_b,
    output logic signed [cme_pkg::PROD_W-1:0]           o_prod
);

    // Exact signed product, registered so the next step starts from a flop.
    logic signed [cme_pkg::PROD_W-1:0] r_prod;
    logic signed [cme_pkg::PROD_W-1:0] n_prod;

    always_comb begin
        n_prod = cme_pkg::PROD_W'(i_a) * cme_pkg::PROD_W'(i_b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> rtl/cubic_multibrot_escape_time.sv
`default_nettype none

// Channel   Direction  Handshake                   Payload
// --------  ---------  --------------------------  -----------------------------------------
// pixel in  input      i_in_valid / o_in_ready     i_pixel_column, i_pixel_row
// result    output     o_out_valid / i_out_ready   o_iterations, o_color_class, o_range_error
// config    input      i_cfg_we (no wait)          i_cfg_index, i_cfg_data
//
// A request runs the loop once for each of n completed iterations, n being at most
// max_iterations + 1; an orbit that stops on an exact fixed point reports max_iterations. Every
// iteration runs four products through the single registered 32x32 multiplier, plus the escape
// test and the p/q terms. Reset is synchronous and active low. The block is ready again once a
// result is loaded; a finished request waits in its last step while the previous result still
// sits unread in the output register.

module cubic_multibrot_escape_time (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    // Pixel request.
    input  wire logic                                        i_in_valid,
    output logic                                             o_in_ready,
    input  wire logic signed [cme_pkg::COORD_BITS-1:0]       i_pixel_column,
    input  wire logic signed [cme_pkg::COORD_BITS-1:0]       i_pixel_row,
    // Result.
    output logic                                             o_out_valid,
    input  wire logic                                        i_out_ready,
    output logic [cme_pkg::ITER_W-1:0]                       o_iterations,
    output logic [cme_pkg::CLASS_W-1:0]                      o_color_class,
    output logic                                             o_range_error,
    // Configuration writes.
    input  wire logic                                        i_cfg_we,
    input  wire logic [cme_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  wire logic [cme_pkg::CFG_DATA_W-1:0]              i_cfg_data
);

    localparam int W  = cme_pkg::WORD_W;
    localparam int PW = cme_pkg::PROD_W;

    // Sequencer states.
    localparam logic [3:0] S_IDLE = 4'd0;  // waiting for a pixel
    localparam logic [3:0] S_CRE  = 4'd1;  // column * x_step
    localparam logic [3:0] S_CIM  = 4'd2;  // row * y_step, form c_re
    localparam logic [3:0] S_CSET = 4'd3;  // form c_im, start x*x
    localparam logic [3:0] S_YY   = 4'd4;  // capture x*x, start y*y
    localparam logic [3:0] S_PQ   = 4'd5;  // escape test, p and q
    localparam logic [3:0] S_XP   = 4'd6;  // start x*p
    localparam logic [3:0] S_YQ   = 4'd7;  // form new x, start y*q
    localparam logic [3:0] S_UPD  = 4'd8;  // form new y, fixed point test
    localparam logic [3:0] S_DONE = 4'd9;  // load the result register

    // Configuration registers.
    logic signed [W-1:0]                   r_x_left;
    logic signed [W-1:0]                   r_y_top;
    logic [cme_pkg::STEP_W-1:0]            r_x_step;
    logic [cme_pkg::STEP_W-1:0]            r_y_step;
    logic [cme_pkg::LIMIT_W-1:0]           r_max_iter;
    logic [cme_pkg::DIM_W-1:0]             r_width;
    logic [cme_pkg::DIM_W-1:0]             r_height;

    // Sequencer and datapath registers.
    logic [3:0]                            r_state,     n_state;
    logic [cme_pkg::DIM_W-1:0]             r_col,       n_col;
    logic [cme_pkg::DIM_W-1:0]             r_row,       n_row;
    logic                                  r_err,       n_err;
    logic signed [W-1:0]                   r_cre,       n_cre;
    logic signed [W-1:0]                   r_cim,       n_cim;
    logic signed [W-1:0]                   r_x,         n_x;
    logic signed [W-1:0]                   r_y,         n_y;
    logic signed [W-1:0]                   r_nx,        n_nx;
    logic signed [W-1:0]                   r_xx,        n_xx;
    logic signed [W-1:0]                   r_p,         n_p;
    logic signed [W-1:0]                   r_q,         n_q;
    logic signed [PW-1:0]                  r_xsq,       n_xsq;
    logic [cme_pkg::ITER_W-1:0]            r_n,         n_n;
    logic                                  r_out_valid, n_out_valid;
    logic [cme_pkg::ITER_W-1:0]            r_out_iter,  n_out_iter;
    logic [cme_pkg::CLASS_W-1:0]           r_out_class, n_out_class;
    logic                                  r_out_err,   n_out_err;

    // Shared multiplier.
    logic signed [W-1:0]                   mul_a;
    logic signed [W-1:0]                   mul_b;
    logic signed [PW-1:0]                  mul_prod;

    cme_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    // Helper terms.
    logic                                  col_bad;
    logic                                  row_bad;
    logic                                  pix_bad;
    logic [PW-1:0]                         disk_sum;
    logic                                  in_disk;
    logic                                  keep_going;
    logic signed [W-1:0]                   yy;
    logic signed [W-1:0]                   ny;
    logic [cme_pkg::ITER_W-1:0]            limit_n;

    assign limit_n = cme_pkg::ITER_W'(r_max_iter);

    // The class tests run in order, red first, so a low limit never hides the color bands.
    function automatic logic [cme_pkg::CLASS_W-1:0] color_of(
        input logic [cme_pkg::ITER_W-1:0] n,
        input logic [cme_pkg::ITER_W-1:0] lim
    );
        if (n < cme_pkg::RED_LIMIT) begin
            return cme_pkg::CLASS_RED;
        end else if (n < cme_pkg::GREEN_LIMIT) begin
            return cme_pkg::CLASS_GREEN;
        end else if (n < cme_pkg::BLUE_LIMIT) begin
            return cme_pkg::CLASS_BLUE;
        end else if (n < lim) begin
            return cme_pkg::CLASS_WHITE;
        end
        return cme_pkg::CLASS_BLACK;
    endfunction

    // A coordinate is out of the image when negative or above the configured image width or height.
    always_comb begin
        col_bad = (cme_pkg::CMP_W'(i_pixel_column) < cme_pkg::CMP_W'(0)) ||
                  (cme_pkg::CMP_W'(i_pixel_column) >
                   cme_pkg::CMP_W'($signed({1'b0, r_width})));
        row_bad = (cme_pkg::CMP_W'(i_pixel_row) < cme_pkg::CMP_W'(0)) ||
                  (cme_pkg::CMP_W'(i_pixel_row) >
                   cme_pkg::CMP_W'($signed({1'b0, r_height})));
        pix_bad = col_bad || row_bad;
    end

    // Escape test on the exact squares; mul_prod holds y*y in the test state.
    always_comb begin
        disk_sum   = $unsigned(r_xsq) + $unsigned(mul_prod);
        in_disk    = cme_pkg::DISK_ALWAYS || (disk_sum <= cme_pkg::DISK_LIMIT);
        keep_going = (r_n <= limit_n) && in_disk;
        yy         = cme_pkg::fx_scale(mul_prod);
        ny         = cme_pkg::sat_word(PW'(cme_pkg::fx_scale(mul_prod)) + PW'(r_cim));
    end

    // Multiplier operand selection by sequencer step.
    always_comb begin
        mul_a = r_x;
        mul_b = r_x;
        case (r_state)
            S_CRE: begin
                mul_a = $signed(W'(r_col));
                mul_b = $signed(W'(r_x_step));
            end
            S_CIM: begin
                mul_a = $signed(W'(r_row));
                mul_b = $signed(W'(r_y_step));
            end
            S_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            S_XP: begin
                mul_a = r_x;
                mul_b = r_p;
            end
            S_YQ: begin
                mul_a = r_y;
                mul_b = r_q;
            end
            S_UPD: begin
                mul_a = r_nx;
                mul_b = r_nx;
            end
            default: begin
                mul_a = r_x;
                mul_b = r_x;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_row       = r_row;
        n_err       = r_err;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_x         = r_x;
        n_y         = r_y;
        n_nx        = r_nx;
        n_xx        = r_xx;
        n_p         = r_p;
        n_q         = r_q;
        n_xsq       = r_xsq;
        n_n         = r_n;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_iter  = r_out_iter;
        n_out_class = r_out_class;
        n_out_err   = r_out_err;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // An out-of-image pixel is evaluated at the bottom-left corner.
                    n_err = pix_bad;
                    n_col = pix_bad ? '0 : cme_pkg::DIM_W'(i_pixel_column);
                    n_row = pix_bad ? r_height : cme_pkg::DIM_W'(i_pixel_row);
                    n_x   = '0;
                    n_y   = '0;
                    n_n   = '0;
                    n_state = S_CRE;
                end
            end
            S_CRE: begin
                n_state = S_CIM;
            end
            S_CIM: begin
                n_cre   = cme_pkg::sat_word(PW'(r_x_left) + mul_prod);
                n_state = S_CSET;
            end
            S_CSET: begin
                n_cim   = cme_pkg::sat_word(PW'(r_y_top) - mul_prod);
                n_state = S_YY;
            end
            S_YY: begin
                n_xsq   = mul_prod;
                n_xx    = cme_pkg::fx_scale(mul_prod);
                n_state = S_PQ;
            end
            S_PQ: begin
                if (keep_going) begin
                    n_p = cme_pkg::sat_word(PW'(r_xx) - PW'(yy) * PW'(3));
                    n_q = cme_pkg::sat_word(PW'(r_xx) * PW'(3) - PW'(yy));
                    n_state = S_XP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_XP: begin
                n_state = S_YQ;
            end
            S_YQ: begin
                n_nx    = cme_pkg::sat_word(PW'(cme_pkg::fx_scale(mul_prod)) + PW'(r_cre));
                n_state = S_UPD;
            end
            S_UPD: begin
                if ((r_nx == r_x) && (ny == r_y)) begin
                    // An exact fixed point never escapes: report the limit.
                    n_n     = limit_n;
                    n_state = S_DONE;
                end else begin
                    n_x     = r_nx;
                    n_y     = ny;
                    n_n     = r_n + cme_pkg::ITER_W'(1);
                    n_state = S_YY;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_iter  = r_n;
                    n_out_class = color_of(r_n, limit_n);
                    n_out_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_col       <= n_col;
        r_row       <= n_row;
        r_err       <= n_err;
        r_cre       <= n_cre;
        r_cim       <= n_cim;
        r_x         <= n_x;
        r_y         <= n_y;
        r_nx        <= n_nx;
        r_xx        <= n_xx;
        r_p         <= n_p;
        r_q         <= n_q;
        r_xsq       <= n_xsq;
        r_n         <= n_n;
        r_out_iter  <= n_out_iter;
        r_out_class <= n_out_class;
        r_out_err   <= n_out_err;
    end

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_left   <= cme_pkg::RST_X_LEFT;
            r_y_top    <= cme_pkg::RST_Y_TOP;
            r_x_step   <= cme_pkg::RST_X_STEP;
            r_y_step   <= cme_pkg::RST_Y_STEP;
            r_max_iter <= cme_pkg::RST_MAX_ITER;
            r_width    <= cme_pkg::RST_WIDTH;
            r_height   <= cme_pkg::RST_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cme_pkg::CFG_X_LEFT:       r_x_left   <= $signed(W'(i_cfg_data));
                cme_pkg::CFG_Y_TOP:        r_y_top    <= $signed(W'(i_cfg_data));
                cme_pkg::CFG_X_STEP:       r_x_step   <= cme_pkg::STEP_W'(i_cfg_data);
                cme_pkg::CFG_Y_STEP:       r_y_step   <= cme_pkg::STEP_W'(i_cfg_data);
                cme_pkg::CFG_MAX_ITER:     r_max_iter <= cme_pkg::LIMIT_W'(i_cfg_data);
                cme_pkg::CFG_IMAGE_WIDTH:  r_width    <= cme_pkg::DIM_W'(i_cfg_data);
                cme_pkg::CFG_IMAGE_HEIGHT: r_height   <= cme_pkg::DIM_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_iterations  = r_out_iter;
    assign o_color_class = r_out_class;
    assign o_range_error = r_out_err;

endmodule

`default_nettype wire

>>> dv/cubic_multibrot_escape_time_checker.sv
`timescale 1ns / 100ps

// Watches the pixel, result and register-write ports of the escape-time block.
// It predicts every pixel request and compares each delivered result against the
// oldest prediction still waiting.
module cubic_multibrot_escape_time_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic signed [cme_pkg::COORD_BITS-1:0]  i_pixel_column,
    input  logic signed [cme_pkg::COORD_BITS-1:0]  i_pixel_row,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic [cme_pkg::ITER_W-1:0]             i_iterations,
    input  logic [cme_pkg::CLASS_W-1:0]            i_color_class,
    input  logic                                   i_range_error,
    input  logic                                   i_cfg_we,
    input  logic [cme_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [cme_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output int                                     o_mismatches,
    output int                                     o_pending,
    output int                                     o_checked,
    output int                                     o_off_image,
    output int                                     o_bounded
);

    localparam longint WORD_MAX     = 64'sh7FFF_FFFF;
    localparam longint WORD_MIN     = -WORD_MAX - 1;
    localparam int     RADIUS_SHIFT = 2 * cme_pkg::FRAC_BITS + 2;

    typedef struct packed {
        logic [cme_pkg::ITER_W-1:0]  iters;
        logic [cme_pkg::CLASS_W-1:0] shade;
        logic                        off_image;
    } t_pixel_result;

    // Shadow copy of the view and limit registers.
    logic signed [cme_pkg::WORD_W-1:0] x_left_q;
    logic signed [cme_pkg::WORD_W-1:0] y_top_q;
    logic [cme_pkg::STEP_W-1:0]        x_step_q;
    logic [cme_pkg::STEP_W-1:0]        y_step_q;
    logic [cme_pkg::LIMIT_W-1:0]       max_iter_q;
    logic [cme_pkg::DIM_W-1:0]         width_q;
    logic [cme_pkg::DIM_W-1:0]         height_q;

    t_pixel_result awaited_escapes[$];
    t_pixel_result want_r;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_off_image  = 0;
        o_bounded    = 0;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) begin
            return WORD_MAX;
        end else if (v < WORD_MIN) begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // Fixed point product, floor rounding, then clamped.
    function automatic longint qmul(input longint a, input longint b);
        return clamp_word((a * b) >>> cme_pkg::FRAC_BITS);
    endfunction

    function automatic bit within_radius(input longint x, input longint y);
        longint unsigned mag;
        mag = x * x + y * y;
        if (RADIUS_SHIFT >= 64) begin
            return 1'b1;
        end
        return mag <= (64'd1 << RADIUS_SHIFT);
    endfunction

    function automatic t_pixel_result escape_time(
        input logic signed [cme_pkg::COORD_BITS-1:0] col_in,
        input logic signed [cme_pkg::COORD_BITS-1:0] row_in
    );
        longint col, row, w, h, lim, c_re, c_im;
        longint x, y, nx, ny, xx, yy, p, q, n;
        t_pixel_result r;
        col = col_in;
        row = row_in;
        w   = width_q;
        h   = height_q;
        lim = max_iter_q;
        r.off_image = 1'b0;
        if (col < 0 || col > w || row < 0 || row > h) begin
            // Pixels off the image are evaluated at the bottom-left corner.
            r.off_image = 1'b1;
            col = 0;
            row = h;
        end
        c_re = clamp_word(longint'(x_left_q) + col * longint'(x_step_q));
        c_im = clamp_word(longint'(y_top_q) - row * longint'(y_step_q));
        x = 0;
        y = 0;
        n = 0;
        while (n <= lim && within_radius(x, y)) begin
            xx = qmul(x, x);
            yy = qmul(y, y);
            p  = clamp_word(xx - 3 * yy);
            q  = clamp_word(3 * xx - yy);
            nx = clamp_word(qmul(x, p) + c_re);
            ny = clamp_word(qmul(y, q) + c_im);
            if (nx == x && ny == y) begin
                // A point that maps exactly onto itself is taken as bounded.
                n = lim;
                break;
            end
            x = nx;
            y = ny;
            n++;
        end
        r.iters = cme_pkg::ITER_W'(n);
        if (n < cme_pkg::RED_LIMIT) begin
            r.shade = cme_pkg::CLASS_RED;
        end else if (n < cme_pkg::GREEN_LIMIT) begin
            r.shade = cme_pkg::CLASS_GREEN;
        end else if (n < cme_pkg::BLUE_LIMIT) begin
            r.shade = cme_pkg::CLASS_BLUE;
        end else if (n < lim) begin
            r.shade = cme_pkg::CLASS_WHITE;
        end else begin
            r.shade = cme_pkg::CLASS_BLACK;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        o_mismatches++;
        $display("[%0t] escape-time mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            x_left_q   = cme_pkg::RST_X_LEFT;
            y_top_q    = cme_pkg::RST_Y_TOP;
            x_step_q   = cme_pkg::RST_X_STEP;
            y_step_q   = cme_pkg::RST_Y_STEP;
            max_iter_q = cme_pkg::RST_MAX_ITER;
            width_q    = cme_pkg::RST_WIDTH;
            height_q   = cme_pkg::RST_HEIGHT;
            awaited_escapes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    cme_pkg::CFG_X_LEFT:       x_left_q   = i_cfg_data;
                    cme_pkg::CFG_Y_TOP:        y_top_q    = i_cfg_data;
                    cme_pkg::CFG_X_STEP:       x_step_q   = i_cfg_data[cme_pkg::STEP_W-1:0];
                    cme_pkg::CFG_Y_STEP:       y_step_q   = i_cfg_data[cme_pkg::STEP_W-1:0];
                    cme_pkg::CFG_MAX_ITER:     max_iter_q = i_cfg_data[cme_pkg::LIMIT_W-1:0];
                    cme_pkg::CFG_IMAGE_WIDTH:  width_q    = i_cfg_data[cme_pkg::DIM_W-1:0];
                    cme_pkg::CFG_IMAGE_HEIGHT: height_q   = i_cfg_data[cme_pkg::DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_escapes.size() == 0) begin
                    report_mismatch("result with no request outstanding", i_iterations, 0);
                end else begin
                    want_r = awaited_escapes.pop_front();
                    if (i_iterations != want_r.iters) begin
                        report_mismatch("iterations", i_iterations, want_r.iters);
                    end
                    if (i_color_class != want_r.shade) begin
                        report_mismatch("color_class", i_color_class, want_r.shade);
                    end
                    if (i_range_error != want_r.off_image) begin
                        report_mismatch("range_error", i_range_error, want_r.off_image);
                    end
                    o_checked++;
                    if (want_r.off_image) begin
                        o_off_image++;
                    end
                    if (want_r.shade == cme_pkg::CLASS_BLACK) begin
                        o_bounded++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited_escapes.push_back(escape_time(i_pixel_column, i_pixel_row));
            end
        end
        o_pending = awaited_escapes.size();
    end

endmodule

>>> dv/cubic_multibrot_escape_time_test.sv
`timescale 1ns / 100ps

// Top of the escape-time testbench. It resets the block once, then walks it through
// a series of register settings. Every setting is loaded while the block is idle,
// followed by a stream of pixel requests. The checker beside the block predicts
// and compares each result; this module only makes stimulus and gives the verdict.
module cubic_multibrot_escape_time_test;

    // The block does not decode this register index, so writes to it must be ignored.
    localparam logic [cme_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    localparam int ONE = 1 << cme_pkg::FRAC_BITS;

    // A slow but correct run: about 500 requests, each running at most the largest
    // iteration limit plus one, plus receiver stalls. The limit is roughly three times
    // the length of such a run.
    localparam int CYCLE_LIMIT = 8_000_000;

    // How the two sides hold off traffic during a phase.
    typedef enum int {PACE_NONE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} t_pace;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_in_valid;
    logic                                  o_in_ready;
    logic signed [cme_pkg::COORD_BITS-1:0] i_pixel_column;
    logic signed [cme_pkg::COORD_BITS-1:0] i_pixel_row;
    logic                                  o_out_valid;
    logic                                  i_out_ready;
    logic [cme_pkg::ITER_W-1:0]            o_iterations;
    logic [cme_pkg::CLASS_W-1:0]           o_color_class;
    logic                                  o_range_error;
    logic                                  i_cfg_we;
    logic [cme_pkg::CFG_IDX_W-1:0]         i_cfg_index;
    logic [cme_pkg::CFG_DATA_W-1:0]        i_cfg_data;

    int mismatch_count;
    int pending_results;
    int checked_results;
    int off_image_results;
    int bounded_results;

    int gap_pct;
    int stall_pct;
    int cur_width;
    int cur_height;
    int pixels_sent;
    int settings_used;
    int cycle_count;

    cubic_multibrot_escape_time DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_iterations   (o_iterations),
        .o_color_class  (o_color_class),
        .o_range_error  (o_range_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    cubic_multibrot_escape_time_checker u_escape_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_pixel_column (i_pixel_column),
        .i_pixel_row    (i_pixel_row),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_iterations   (o_iterations),
        .i_color_class  (o_color_class),
        .i_range_error  (o_range_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_mismatches   (mismatch_count),
        .o_pending      (pending_results),
        .o_checked      (checked_results),
        .o_off_image    (off_image_results),
        .o_bounded      (bounded_results)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Watchdog. If the run hangs, this process ends it.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("cubic_multibrot_escape_time_test: FAIL");
        $finish;
    end

    // The result side makes a fresh ready decision at every falling edge. The
    // stall percentage comes from the current pacing mode.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic set_pace(input t_pace mode);
        case (mode)
            PACE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
            PACE_SENDER:   begin gap_pct = 67; stall_pct = 0;  end
            PACE_RECEIVER: begin gap_pct = 0;  stall_pct = 67; end
            default:       begin gap_pct = 28; stall_pct = 28; end
        endcase
    endtask

    // The write port has no handshake. A write lasts one cycle, starting at a falling edge.
    task automatic write_reg(input logic [cme_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cme_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Loads a whole view. Only called while no request is in flight.
    task automatic set_view(input logic [31:0] left, input logic [31:0] top,
                            input logic [31:0] xs, input logic [31:0] ys,
                            input logic [31:0] lim, input logic [31:0] w,
                            input logic [31:0] h);
        write_reg(cme_pkg::CFG_X_LEFT, left);
        write_reg(cme_pkg::CFG_Y_TOP, top);
        write_reg(cme_pkg::CFG_X_STEP, xs);
        write_reg(cme_pkg::CFG_Y_STEP, ys);
        write_reg(cme_pkg::CFG_MAX_ITER, lim);
        write_reg(cme_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(cme_pkg::CFG_IMAGE_HEIGHT, h);
        cur_width  = int'(w[cme_pkg::DIM_W-1:0]);
        cur_height = int'(h[cme_pkg::DIM_W-1:0]);
        settings_used++;
    endtask

    // Offers one pixel request, starting at a falling edge. It returns at the falling
    // edge after acceptance with valid still high. The next call either replaces the
    // payload right away or lowers valid for a gap, so valid never drops and rises
    // within one step.
    task automatic send_pixel(input logic signed [cme_pkg::COORD_BITS-1:0] col,
                              input logic signed [cme_pkg::COORD_BITS-1:0] row);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid = 1'b0;
            do begin
                @(negedge i_clk);
            end while ($urandom_range(99) < gap_pct);
        end
        i_in_valid     = 1'b1;
        i_pixel_column = col;
        i_pixel_row    = row;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        @(negedge i_clk);
        pixels_sent++;
    endtask

    // Drops valid and holds off until every outstanding request has produced its result.
    task automatic wait_drain();
        i_in_valid = 1'b0;
        while (pending_results != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Sends a stream of random pixels. Most fall inside the current image, and the
    // rest use the full 13-bit coordinate range. Halfway through, the sender pauses
    // until the pipeline is empty. With near_core set, the pixels are drawn from
    // the interior of the default view, where points rarely escape.
    task automatic run_batch(input int count, input bit near_core);
        logic signed [cme_pkg::COORD_BITS-1:0] col;
        logic signed [cme_pkg::COORD_BITS-1:0] row;
        for (int i = 0; i < count; i++) begin
            if (count > 1 && i == count / 2) begin
                wait_drain();
            end
            if (near_core) begin
                col = cme_pkg::COORD_BITS'($urandom_range(700, 450));
                row = cme_pkg::COORD_BITS'($urandom_range(650, 350));
            end else if ($urandom_range(99) < 85) begin
                col = cme_pkg::COORD_BITS'($urandom_range(cur_width));
                row = cme_pkg::COORD_BITS'($urandom_range(cur_height));
            end else begin
                col = cme_pkg::COORD_BITS'($urandom);
                row = cme_pkg::COORD_BITS'($urandom);
            end
            send_pixel(col, row);
        end
        wait_drain();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_pixel_column = '0;
        i_pixel_row    = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = cme_pkg::CFG_X_LEFT;
        i_cfg_data     = '0;
        pixels_sent    = 0;
        settings_used  = 1;
        cur_width      = int'(cme_pkg::RST_WIDTH);
        cur_height     = int'(cme_pkg::RST_HEIGHT);
        set_pace(PACE_NONE);

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests run on the reset view, which covers [-2, 1] x [-1, 1]
        // at 1000x1000. They hit the image corners, the pixels just past each
        // edge, and the most negative and most positive coordinates. Two pixels
        // lie well inside the set.
        send_pixel(0, 0);
        send_pixel(1000, 1000);
        send_pixel(0, 1000);
        send_pixel(1000, 0);
        send_pixel(-1, 0);
        send_pixel(0, -1);
        send_pixel(1001, 500);
        send_pixel(500, 1001);
        send_pixel(-4096, -4096);
        send_pixel(4095, 4095);
        send_pixel(4095, -4096);
        send_pixel(500, 500);
        send_pixel(667, 500);
        wait_drain();

        // With zero corner and zero steps, every pixel maps to c = 0. The orbit
        // then lands on its own fixed point at once. This runs first with the
        // largest limit and then with a zero limit. A write to the undecoded
        // index must change nothing.
        set_view(0, 0, 0, 0, 1023, 4095, 4095);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        send_pixel(0, 0);
        send_pixel(4095, 4095);
        send_pixel(-1, -1);
        wait_drain();
        set_view(0, 0, 0, 0, 0, 4095, 4095);
        send_pixel(2048, 17);
        send_pixel(-4096, 4095);
        wait_drain();

        // Extreme registers: the corner sits at the most negative real and most
        // positive imaginary value. Upper data bits are set on every masked
        // register, so the steps, limit and sizes come out at their maxima.
        // Far pixels saturate c.
        set_pace(PACE_SENDER);
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pixel(4095, 4095);
        send_pixel(8, 8);
        run_batch(22, 1'b0);

        // A tiny image, with width and height set to 1. Almost everything is off the image and
        // folds onto the corner pixel.
        set_pace(PACE_RECEIVER);
        set_view(32'(cme_pkg::RST_X_LEFT), 32'(cme_pkg::RST_Y_TOP),
                 32'(cme_pkg::RST_X_STEP), 32'(cme_pkg::RST_Y_STEP), 10, 1, 1);
        send_pixel(1, 1);
        send_pixel(2, 0);
        send_pixel(0, 2);
        run_batch(16, 1'b0);

        // Back to the reset registers, then a few interior points at the largest
        // limit. These are the slowest requests of the run.
        set_pace(PACE_BOTH);
        set_view(32'(cme_pkg::RST_X_LEFT), 32'(cme_pkg::RST_Y_TOP),
                 32'(cme_pkg::RST_X_STEP), 32'(cme_pkg::RST_Y_STEP),
                 32'(cme_pkg::RST_MAX_ITER), 32'(cme_pkg::RST_WIDTH),
                 32'(cme_pkg::RST_HEIGHT));
        run_batch(20, 1'b0);
        set_pace(PACE_NONE);
        set_view(32'(cme_pkg::RST_X_LEFT), 32'(cme_pkg::RST_Y_TOP),
                 32'(cme_pkg::RST_X_STEP), 32'(cme_pkg::RST_Y_STEP), 1023,
                 32'(cme_pkg::RST_WIDTH), 32'(cme_pkg::RST_HEIGHT));
        run_batch(6, 1'b1);

        // Random views near the set with small limits, so that the counts land on
        // every color boundary. The pacing mode rotates from one view to the next.
        for (int k = 0; k < 9; k++) begin
            int left, top, xs, ys, lim, w, h;
            w    = $urandom_range(255, 16);
            h    = $urandom_range(255, 16);
            xs   = $urandom_range(ONE / 48, ONE / 160);
            ys   = $urandom_range(ONE / 48, ONE / 160);
            left = -int'($urandom_range(2 * ONE, ONE / 2));
            top  = $urandom_range(2 * ONE, ONE / 2);
            lim  = $urandom_range(64, 1);
            set_pace(t_pace'(k % 4));
            set_view(left, top, xs, ys, lim, w, h);
            run_batch(45, 1'b0);
        end

        // Keep the result side open for a while, so that any stray result shows up.
        set_pace(PACE_NONE);
        wait_drain();
        repeat (64) @(negedge i_clk);

        $display("Sent %0d pixel requests across %0d register settings; %0d results checked.",
                 pixels_sent, settings_used, checked_results);
        $display("Of those, %0d were off the image and %0d stayed bounded.",
                 off_image_results, bounded_results);
        if (mismatch_count == 0 && pending_results == 0) begin
            $display("cubic_multibrot_escape_time_test: PASS");
        end else begin
            $display("cubic_multibrot_escape_time_test: FAIL");
        end
        $finish;
    end

endmodule
